// ===== rtl/core/msrr_pkg.sv =====
// Shared types and constants for the middle-square random range core.
`timescale 1ns / 1ps
package msrr_pkg;
   localparam int SeedW = 14;
   localparam int ValW = 16;
   localparam int SqW = 28;
   localparam int ProdW = 45;
   localparam int SeedReset = 1000;

   typedef enum logic [0:0] {
      CMD_DRAW = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      logic load_seed;
      logic start_draw;
      logic step;
   } ctrl_type;

   typedef struct packed {
      logic done;
   } stat_type;

   // Returns ten to the power e for e up to nine.
   function automatic logic [SqW+1:0] pow10(input logic [3:0] e);
      logic [SqW+1:0] p;
      p = '0;
      case (e)
         4'd0: p = 30'd1;
         4'd1: p = 30'd10;
         4'd2: p = 30'd100;
         4'd3: p = 30'd1000;
         4'd4: p = 30'd10000;
         4'd5: p = 30'd100000;
         4'd6: p = 30'd1000000;
         4'd7: p = 30'd10000000;
         4'd8: p = 30'd100000000;
         4'd9: p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction
endpackage

// ===== rtl/core/msrr_datapath.sv =====
// Datapath: seed register, serial squarer, digit count, span multiplier and restoring dividers.
`timescale 1ns / 1ps
module msrr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  msrr_pkg::ctrl_type             ctrl,
   output msrr_pkg::stat_type             stat,
   input  logic [15:0]                    range_low,
   input  logic [15:0]                    range_high,
   input  logic [msrr_pkg::SeedW-1:0]     new_seed_value,
   output logic [msrr_pkg::ValW-1:0]      random_value,
   output logic [msrr_pkg::SeedW-1:0]     seed_after
);
   localparam int SW = msrr_pkg::SeedW;
   localparam int QW = msrr_pkg::SqW;
   localparam int PW = msrr_pkg::ProdW;

   logic [SW-1:0] seed_ff, seed_in;
   logic [QW-1:0] sq_ff, sq_in;
   logic [SW-1:0] mplr_ff, mplr_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [QW+1:0] rem_ff, rem_in;
   logic [QW+1:0] srem_ff, srem_in;
   logic [QW-1:0] squo_ff, squo_in;
   logic [3:0] dig_ff, dig_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] ph_ff, ph_in;
   logic [16:0] span_ff, span_in;
   logic inv_ff, inv_in;
   logic [15:0] lo_ff, lo_in;
   logic [msrr_pkg::ValW-1:0] val_ff, val_in;
   logic done_in;

   logic [QW+1:0] scale, rdiv;
   logic [3:0] start, right;
   logic [QW+1:0] rtrial, strial;
   logic [QW+2:0] rsh, ssh;
   logic [16:0] lsum;
   logic [QW-1:0] msub;

   always_comb begin
      start = (dig_ff - 4'd4) >> 1;
      right = dig_ff - start - 4'd4;
      scale = msrr_pkg::pow10(dig_ff);
      rdiv = msrr_pkg::pow10(right);
      rsh = {rem_ff, quo_ff[PW-1]};
      ssh = {srem_ff, squo_ff[QW-1]};
      rtrial = rsh[QW+1:0] - scale;
      strial = ssh[QW+1:0] - rdiv;
      lsum = {1'b0, lo_ff} + quo_ff[16:0];
      msub = QW'(14'd10000) << (cnt_ff - 6'd1);
   end

   always_comb begin
      seed_in = seed_ff; sq_in = sq_ff; mplr_in = mplr_ff; prod_in = prod_ff;
      quo_in = quo_ff; rem_in = rem_ff; srem_in = srem_ff; squo_in = squo_ff;
      dig_in = dig_ff; cnt_in = cnt_ff; ph_in = ph_ff; span_in = span_ff;
      inv_in = inv_ff; lo_in = lo_ff; val_in = val_ff; done_in = 1'b0;
      if (ctrl.load_seed) begin
         seed_in = new_seed_value;
         val_in = '0;
         done_in = 1'b1;
      end else if (ctrl.start_draw) begin
         sq_in = '0; mplr_in = seed_ff; cnt_in = 6'(SW); ph_in = 3'd0;
         lo_in = range_low; inv_in = range_high < range_low;
         span_in = {1'b0, range_high} - {1'b0, range_low} + 17'd1;
      end else if (ctrl.step) begin
         case (ph_ff)
            3'd0: begin
               sq_in = (sq_ff << 1) + (mplr_ff[SW-1] ? QW'(seed_ff) : '0);
               mplr_in = mplr_ff << 1;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  ph_in = 3'd1; dig_in = 4'd1;
               end
            end
            3'd1: begin
               if ({2'b0, sq_in} >= msrr_pkg::pow10(dig_ff) && dig_ff != 4'd9)
                  dig_in = dig_ff + 4'd1;
               else begin
                  ph_in = 3'd2; prod_in = '0; mplr_in = '0;
                  span_in = span_ff; cnt_in = 6'd17;
               end
            end
            3'd2: begin
               prod_in = (prod_ff << 1) + (span_ff[16] ? PW'(sq_ff) : '0);
               span_in = span_ff << 1;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  ph_in = 3'd3; quo_in = prod_in; rem_in = '0; cnt_in = 6'(PW);
               end
            end
            3'd3: begin
               if (rsh[QW+2] || rsh[QW+1:0] >= scale) begin
                  rem_in = rtrial; quo_in = {quo_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rsh[QW+1:0]; quo_in = {quo_ff[PW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  ph_in = 3'd4; squo_in = sq_ff; srem_in = '0; cnt_in = 6'(QW);
               end
            end
            3'd4: begin
               if (ssh[QW+2] || ssh[QW+1:0] >= rdiv) begin
                  srem_in = strial; squo_in = {squo_ff[QW-2:0], 1'b1};
               end else begin
                  srem_in = ssh[QW+1:0]; squo_in = {squo_ff[QW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  ph_in = 3'd5; cnt_in = 6'd7;
               end
            end
            3'd5: begin
               // The shifted quotient stays below one million, so seven
               // compare-and-subtract steps leave its last four digits.
               if (squo_ff >= msub) squo_in = squo_ff - msub;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) ph_in = 3'd6;
            end
            default: begin
               val_in = inv_ff ? lo_ff : lsum[15:0];
               if (dig_ff < 4'd4) seed_in = sq_ff[SW-1:0];
               else seed_in = squo_ff[SW-1:0];
               done_in = 1'b1;
               ph_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SW'(msrr_pkg::SeedReset);
         ph_ff <= 3'd0;
      end else begin
         seed_ff <= seed_in;
         ph_ff <= ph_in;
      end
      sq_ff <= sq_in; mplr_ff <= mplr_in; prod_ff <= prod_in; quo_ff <= quo_in;
      rem_ff <= rem_in; srem_ff <= srem_in; squo_ff <= squo_in; dig_ff <= dig_in;
      cnt_ff <= cnt_in; span_ff <= span_in; inv_ff <= inv_in; lo_ff <= lo_in;
      val_ff <= val_in;
   end

   assign stat.done = done_in;
   assign random_value = val_in;
   assign seed_after = seed_in;
endmodule

// ===== rtl/core/msrr_control.sv =====
// Controller state machine sequencing one beat through the datapath.
`timescale 1ns / 1ps
module msrr_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               req_cmd,
   input  logic               rsp_tready,
   input  msrr_pkg::stat_type stat,
   output msrr_pkg::ctrl_type ctrl,
   output logic               req_tready,
   output logic               out_load
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == msrr_pkg::CMD_LOAD) ctrl.load_seed = 1'b1;
               else begin
                  ctrl.start_draw = 1'b1;
                  state_in = ST_BUSY;
               end
            end
         end
         ST_BUSY: begin
            ctrl.step = 1'b1;
            if (stat.done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign out_load = stat.done;
   assign req_tready = (state_ff == ST_IDLE) && rsp_tready;
endmodule

// ===== rtl/core/middle_square_random_range_core.sv =====
// Top level of the middle-square random range core.
// A reseed beat presents its result in the cycle after acceptance.
// A draw beat runs the squarer, the digit count, the span multiply, the two divides,
// the remainder reduction and a finish step before it presents its result.
// A new beat is accepted only after the previous result has been taken.
// Reset is synchronous and sets the seed to 1000.
`timescale 1ns / 1ps
module middle_square_random_range_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd, range_low, range_high, new_seed_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // random_value, seed_after
);
   msrr_pkg::ctrl_type ctrl;
   msrr_pkg::stat_type stat;
   logic req_fire, out_load;
   logic [15:0] val;
   logic [13:0] seed;
   logic rv_ff;
   logic [29:0] rd_ff;

   assign req_fire = req_tvalid && req_tready;

   msrr_control u_ctl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_cmd(req_tdata[0]),
      .rsp_tready(rsp_tready && !rv_ff), .stat(stat), .ctrl(ctrl),
      .req_tready(req_tready), .out_load(out_load)
   );

   msrr_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .range_low(req_tdata[16:1]), .range_high(req_tdata[32:17]),
      .new_seed_value(req_tdata[46:33]), .random_value(val), .seed_after(seed)
   );

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (out_load) rv_ff <= 1'b1;
      else if (rsp_tready) rv_ff <= 1'b0;
      if (out_load) rd_ff <= {seed, val};
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {2'b0, rd_ff};

   // A waiting result beat holds its valid and its data until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid);
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata));
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready);
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the middle-square random range core.
`timescale 1ns / 1ps
class seed_scoreboard;
   logic [13:0] seed;
   logic [15:0] exp_val[$];
   logic [13:0] exp_seed[$];
   int errors;

   function new();
      seed = 14'd1000;
      errors = 0;
   endfunction

   function void note_beat(logic cmd, logic [15:0] lo, logic [15:0] hi, logic [13:0] nsv);
      longint unsigned sq, scale, v, nxt, tmp;
      int d, start, right;
      if (cmd == msrr_pkg::CMD_LOAD) begin
         seed = nsv;
         exp_val.push_back(16'd0);
         exp_seed.push_back(seed);
         return;
      end
      sq = longint'(seed) * longint'(seed);
      d = 1;
      tmp = sq;
      while (tmp >= 10) begin
         tmp = tmp / 10;
         d++;
      end
      scale = 1;
      for (int i = 0; i < d; i++) scale = scale * 10;
      if (hi < lo) v = lo;
      else v = lo + (sq * (longint'(hi) - longint'(lo) + 1)) / scale;
      if (d < 4) nxt = sq;
      else begin
         start = (d - 4) / 2;
         right = d - start - 4;
         tmp = 1;
         for (int i = 0; i < right; i++) tmp = tmp * 10;
         nxt = (sq / tmp) % 10000;
      end
      seed = nxt[13:0];
      exp_val.push_back(v[15:0]);
      exp_seed.push_back(seed);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_beat(logic [31:0] data);
      logic [15:0] ev;
      logic [13:0] es;
      if (exp_val.size() == 0) begin
         report($sformatf("unexpected beat %h", data));
         return;
      end
      ev = exp_val.pop_front();
      es = exp_seed.pop_front();
      if (data[15:0] !== ev) report($sformatf("value %0d exp %0d", data[15:0], ev));
      if (data[29:16] !== es) report($sformatf("seed %0d exp %0d", data[29:16], es));
      if (data[31:30] !== 2'b00) report("pad bits set");
   endtask
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   seed_scoreboard sb = new();
   longint cycles = 0;

   middle_square_random_range_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
   end

   // Receiver: waits a random number of cycles per beat, then stays ready until it is taken.
   initial begin
      int w;
      rsp_tready = 0;
      forever begin
         w = $urandom_range(0, 6);
         repeat (w) @(negedge clock);
         rsp_tready = 1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1) && !reset);
         @(negedge clock);
         rsp_tready = 0;
      end
   end

   task automatic send_beat(logic cmd, logic [15:0] lo, logic [15:0] hi, logic [13:0] nsv);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_tdata = {1'b0, nsv, hi, lo, cmd};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(cmd, lo, hi, nsv);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   initial begin
      logic [15:0] a, b;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // Directed part: field extremes, short squares, inverted range, oversized seed.
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'hFFFF, 14'd0);
      send_beat(msrr_pkg::CMD_DRAW, 16'hFFFF, 16'hFFFF, 14'd0);
      send_beat(msrr_pkg::CMD_DRAW, 16'd500, 16'd100, 14'd0);
      send_beat(msrr_pkg::CMD_LOAD, 16'hFFFF, 16'd0, 14'd0);
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'd10, 14'd0);
      send_beat(msrr_pkg::CMD_LOAD, 16'd0, 16'd0, 14'd5);
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'd100, 14'd0);
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'd100, 14'd0);
      send_beat(msrr_pkg::CMD_LOAD, 16'd0, 16'd0, 14'd31);
      send_beat(msrr_pkg::CMD_DRAW, 16'd7, 16'd7, 14'd0);
      send_beat(msrr_pkg::CMD_LOAD, 16'd0, 16'd0, 14'd9999);
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'hFFFF, 14'd0);
      send_beat(msrr_pkg::CMD_LOAD, 16'd0, 16'd0, 14'h3FFF);
      send_beat(msrr_pkg::CMD_DRAW, 16'd0, 16'hFFFF, 14'd0);
      send_beat(msrr_pkg::CMD_DRAW, 16'hFFFF, 16'd0, 14'h3FFF);
      send_beat(msrr_pkg::CMD_LOAD, 16'd0, 16'd0, 14'd1234);
      send_beat(msrr_pkg::CMD_DRAW, 16'h8000, 16'hFFFE, 14'd0);
      // Random part, mostly draws.
      for (int i = 0; i < 1030; i++) begin
         a = $urandom;
         b = $urandom;
         if ($urandom_range(0, 9) == 0)
            send_beat(msrr_pkg::CMD_LOAD, a, b, ($urandom_range(0, 7) == 0) ?
                      14'($urandom) : 14'($urandom_range(0, 9999)));
         else if ($urandom_range(0, 5) == 0)
            send_beat(msrr_pkg::CMD_DRAW, a, b, 14'($urandom));
         else if (a <= b) send_beat(msrr_pkg::CMD_DRAW, a, b, 14'($urandom));
         else send_beat(msrr_pkg::CMD_DRAW, b, a, 14'($urandom));
      end
      while (sb.exp_val.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
